// File: design/ctc_pkg.sv
package ctc_pkg;

  localparam int unsigned SecW = 17;

  localparam logic [SecW-1:0] MaxIntervalLimit = 17'd86399;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned StepBig     = 10;
  localparam int unsigned StepMid     = 5;

  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_SET_HOURS   = 3'd1,
    MODE_SET_MINUTES = 3'd2,
    MODE_SET_SECONDS = 3'd3,
    MODE_RUNNING     = 3'd4,
    MODE_PAUSED      = 3'd5,
    MODE_ALERT       = 3'd6,
    MODE_CLEARING    = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    EV_SELECT      = 3'd0,
    EV_LONG_SELECT = 3'd1,
    EV_UP          = 3'd2,
    EV_DOWN        = 3'd3,
    EV_TICK        = 3'd4,
    EV_DISMISS     = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    FOCUS_NONE    = 3'd0,
    FOCUS_HOURS   = 3'd1,
    FOCUS_MINUTES = 3'd2,
    FOCUS_SECONDS = 3'd3,
    FOCUS_ALERT   = 3'd4
  } highlight_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] repeat_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      state_code;
    logic [SecW-1:0] shown_seconds;
    logic [2:0]      highlight;
    logic            vibrate;
    logic            handled;
  } out_item_t;

  // Control from the state machine to the interval adjuster.
  typedef struct packed {
    mode_e      field;
    logic       up;
    logic [3:0] max_step;
  } adj_ctrl_t;

  function automatic logic [3:0] step_count(input logic [7:0] repeat_count);
    logic [3:0] n;
    if (repeat_count > 8'(StepBig)) begin
      n = 4'(StepBig);
    end else if (repeat_count > 8'(StepMid)) begin
      n = 4'(StepMid);
    end else begin
      n = 4'd1;
    end
    return n;
  endfunction

endpackage

// File: design/ctc_stream_if.sv
interface ctc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/countdown_timer_controller.sv
// Countdown timer controller.
// in_i carries one button or tick event per transfer (mode, repeat_count);
// out_o returns exactly one status item per event: mode after the event,
// seconds to display, highlighted field, vibrate pulse and up/down handled.
// Both channels use valid/ready; a transfer happens when both are high.
// An event goes through an input register, then the state update and result
// are formed combinationally and written into the output register, one event
// per cycle sustained while the receiver does not stall.
// When the receiver stalls, the output register holds its item and the input
// register takes one more event; ready then drops until the output drains.
// cfg_we_i/cfg_wdata_i write the maximum settable interval in seconds;
// values above 86399 saturate. Write it only while no event is in flight.
// Reset puts the timer idle with a zero interval and zero remaining time,
// no highlight, maximum interval 86399, and both registers empty.
module countdown_timer_controller (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ctc_pkg::SecW-1:0] cfg_wdata_i,
  ctc_stream_if.sink               in_i,
  ctc_stream_if.source             out_o
);

  logic [ctc_pkg::SecW-1:0] max_interval_q;
  logic                     in_valid_q;
  ctc_pkg::in_item_t        in_data_q;
  logic                     out_valid_q;
  ctc_pkg::out_item_t       out_data_q;
  ctc_pkg::out_item_t       result;
  logic                     advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_interval_q <= ctc_pkg::MaxIntervalLimit;
    end else if (cfg_we_i) begin
      max_interval_q <= (cfg_wdata_i > ctc_pkg::MaxIntervalLimit) ?
                        ctc_pkg::MaxIntervalLimit : cfg_wdata_i;
    end
  end

  // Advance the held event when the output slot is free or being drained.
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_data_q <= in_i.data;
    end
  end

  ctc_fsm u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .item_i         (in_data_q),
    .max_interval_i (max_interval_q),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

endmodule

// File: design/ctc_adjust.sv
module ctc_adjust (
  input  ctc_pkg::adj_ctrl_t               ctrl_i,
  input  logic [ctc_pkg::SecW-1:0]         interval_i,
  input  logic [ctc_pkg::SecW-1:0]         max_interval_i,
  output logic [ctc_pkg::SecW-1:0]         interval_o
);

  logic [ctc_pkg::SecW-1:0] amt;
  logic [ctc_pkg::SecW-1:0] best;
  logic [ctc_pkg::SecW-1:0] headroom;
  logic                     fits;

  // Pick the largest step multiple, up to the requested step, that keeps the
  // interval within zero and the maximum.
  always_comb begin
    amt  = '0;
    fits = 1'b0;
    best = '0;
    headroom = (interval_i > max_interval_i) ? '0 : (max_interval_i - interval_i);
    for (int k = 1; k <= int'(ctc_pkg::StepBig); k++) begin
      unique case (ctrl_i.field)
        ctc_pkg::MODE_SET_HOURS:   amt = ctc_pkg::SecW'(k * ctc_pkg::SecsPerHour);
        ctc_pkg::MODE_SET_MINUTES: amt = ctc_pkg::SecW'(k * ctc_pkg::SecsPerMin);
        default:                   amt = ctc_pkg::SecW'(k);
      endcase
      fits = ctrl_i.up ? (amt <= headroom) : (amt <= interval_i);
      if ((4'(k) <= ctrl_i.max_step) && fits) begin
        best = amt;
      end
    end
    interval_o = ctrl_i.up ? (interval_i + best) : (interval_i - best);
  end

endmodule

// File: design/ctc_fsm.sv
module ctc_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  ctc_pkg::in_item_t             item_i,
  input  logic [ctc_pkg::SecW-1:0]      max_interval_i,
  output ctc_pkg::out_item_t            result_o
);

  ctc_pkg::mode_e           mode_q, mode_d;
  ctc_pkg::highlight_e      hl_q, hl_d;
  logic [ctc_pkg::SecW-1:0] interval_q, interval_d;
  logic [ctc_pkg::SecW-1:0] remaining_q, remaining_d;
  logic [ctc_pkg::SecW-1:0] remaining_dec;
  logic [ctc_pkg::SecW-1:0] adj_interval;
  ctc_pkg::adj_ctrl_t       adj_ctrl;
  ctc_pkg::event_e          ev;
  logic                     setting;
  logic                     vibrate;
  logic                     handled;

  assign ev      = ctc_pkg::event_e'(item_i.mode);
  assign setting = (mode_q == ctc_pkg::MODE_SET_HOURS) ||
                   (mode_q == ctc_pkg::MODE_SET_MINUTES) ||
                   (mode_q == ctc_pkg::MODE_SET_SECONDS);

  assign adj_ctrl.field    = mode_q;
  assign adj_ctrl.up       = (ev == ctc_pkg::EV_UP);
  assign adj_ctrl.max_step = ctc_pkg::step_count(item_i.repeat_count);

  ctc_adjust u_adjust (
    .ctrl_i         (adj_ctrl),
    .interval_i     (interval_q),
    .max_interval_i (max_interval_i),
    .interval_o     (adj_interval)
  );

  // Hold at zero instead of wrapping.
  assign remaining_dec = (remaining_q != '0) ? (remaining_q - 1'b1) : '0;

  always_comb begin
    mode_d      = mode_q;
    hl_d        = hl_q;
    interval_d  = interval_q;
    remaining_d = remaining_q;
    unique case (ev)
      ctc_pkg::EV_SELECT: begin
        unique case (mode_q)
          ctc_pkg::MODE_IDLE: begin
            mode_d      = ctc_pkg::MODE_RUNNING;
            remaining_d = interval_q;
          end
          ctc_pkg::MODE_RUNNING: mode_d = ctc_pkg::MODE_PAUSED;
          ctc_pkg::MODE_PAUSED:  mode_d = ctc_pkg::MODE_RUNNING;
          ctc_pkg::MODE_SET_HOURS: begin
            mode_d = ctc_pkg::MODE_SET_SECONDS;
            hl_d   = ctc_pkg::FOCUS_SECONDS;
          end
          ctc_pkg::MODE_SET_MINUTES: begin
            mode_d = ctc_pkg::MODE_SET_HOURS;
            hl_d   = ctc_pkg::FOCUS_HOURS;
          end
          ctc_pkg::MODE_SET_SECONDS: begin
            mode_d = ctc_pkg::MODE_SET_MINUTES;
            hl_d   = ctc_pkg::FOCUS_MINUTES;
          end
          default: ;
        endcase
      end
      ctc_pkg::EV_LONG_SELECT: begin
        if (mode_q == ctc_pkg::MODE_IDLE) begin
          mode_d = ctc_pkg::MODE_SET_MINUTES;
          hl_d   = ctc_pkg::FOCUS_MINUTES;
        end else if (setting) begin
          mode_d = ctc_pkg::MODE_IDLE;
          hl_d   = ctc_pkg::FOCUS_NONE;
        end
      end
      ctc_pkg::EV_UP: begin
        if (setting) begin
          interval_d = adj_interval;
        end else if ((mode_q == ctc_pkg::MODE_RUNNING) ||
                     (mode_q == ctc_pkg::MODE_PAUSED)) begin
          mode_d = ctc_pkg::MODE_IDLE;
        end
      end
      ctc_pkg::EV_DOWN: begin
        if (setting) begin
          interval_d = adj_interval;
        end
      end
      ctc_pkg::EV_TICK: begin
        if (mode_q == ctc_pkg::MODE_RUNNING) begin
          remaining_d = remaining_dec;
          if (remaining_dec == '0) begin
            mode_d = ctc_pkg::MODE_ALERT;
            hl_d   = ctc_pkg::FOCUS_ALERT;
          end
        end else if (mode_q == ctc_pkg::MODE_CLEARING) begin
          mode_d = ctc_pkg::MODE_IDLE;
        end
      end
      ctc_pkg::EV_DISMISS: begin
        if (mode_q == ctc_pkg::MODE_ALERT) begin
          mode_d = ctc_pkg::MODE_CLEARING;
          hl_d   = ctc_pkg::FOCUS_NONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    vibrate = 1'b0;
    handled = 1'b0;
    unique case (ev)
      ctc_pkg::EV_UP: handled = setting || (mode_q == ctc_pkg::MODE_RUNNING) ||
                                (mode_q == ctc_pkg::MODE_PAUSED);
      ctc_pkg::EV_DOWN: handled = setting;
      ctc_pkg::EV_TICK: vibrate = (mode_q == ctc_pkg::MODE_ALERT) ||
                                  ((mode_q == ctc_pkg::MODE_RUNNING) &&
                                   (remaining_dec == '0));
      default: ;
    endcase

    result_o.state_code = mode_d;
    result_o.highlight  = hl_d;
    result_o.vibrate    = vibrate;
    result_o.handled    = handled;
    unique case (mode_d)
      ctc_pkg::MODE_RUNNING,
      ctc_pkg::MODE_PAUSED:  result_o.shown_seconds = remaining_d;
      ctc_pkg::MODE_ALERT,
      ctc_pkg::MODE_CLEARING: result_o.shown_seconds = '0;
      default:               result_o.shown_seconds = interval_d;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ctc_pkg::MODE_IDLE;
      hl_q        <= ctc_pkg::FOCUS_NONE;
      interval_q  <= '0;
      remaining_q <= '0;
    end else if (advance_i) begin
      mode_q      <= mode_d;
      hl_q        <= hl_d;
      interval_q  <= interval_d;
      remaining_q <= remaining_d;
    end
  end

endmodule
